// ----- rtl/impulse_response_convolver_defines.svh -----
// Assertion macros for the impulse response convolver.
// Used by the top level only; each macro expects i_clk and i_rst_n in scope.
`ifndef IMPULSE_RESPONSE_CONVOLVER_DEFINES_SVH
`define IMPULSE_RESPONSE_CONVOLVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/irc_pkg.sv -----
// Shared constants, command codes and controller/datapath structs for the
// impulse response convolver. No dependencies.
`default_nettype none

package irc_pkg;

    localparam int CMD_W           = 2;
    localparam int TAP_INDEX_W     = 10;
    localparam int TAP_COUNT_W     = 11;
    localparam int ACC_W           = 64;
    localparam int DEF_MAX_TAPS    = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PROC  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic tap_we;   // write the tap store from the input transfer
        logic hist_we;  // write the sample into the history ring
        logic start;    // begin a new sum
        logic issue;    // read one tap and one history entry
        logic emit;     // round, saturate and load the output register
        logic clear;    // empty the history
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_busy;  // reads or products still on their way into the accumulator
        logic out_free;   // output register can take a result this cycle
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- rtl/irc_if.sv -----
// Valid/ready channel interfaces for the convolver input and result streams.
// Depends on irc_pkg.
`default_nettype none

interface irc_in_if #(
    parameter int SAMPLE_BITS = irc_pkg::DEF_SAMPLE_BITS
);
    import irc_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [CMD_W-1:0]              command;
    logic [TAP_INDEX_W-1:0]        tap_index;
    logic signed [SAMPLE_BITS-1:0] value;

    modport source (output valid, output command, output tap_index, output value,
                    input ready);
    modport sink   (input valid, input command, input tap_index, input value,
                    output ready);
endinterface

interface irc_out_if #(
    parameter int SAMPLE_BITS = irc_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

`default_nettype wire

// ----- rtl/irc_ctrl.sv -----
// Controller for the convolver: holds the tap count register and sequences
// one multiply-accumulate per tap. Depends on irc_pkg.
`default_nettype none

module irc_ctrl #(
    parameter int MAX_TAPS = irc_pkg::DEF_MAX_TAPS
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [irc_pkg::TAP_COUNT_W-1:0]    i_cfg_wdata,
    input  wire                                i_valid,
    input  wire  [irc_pkg::CMD_W-1:0]          i_command,
    output logic                               o_ready,
    input  irc_pkg::t_dp_stat                  i_stat,
    output irc_pkg::t_dp_cmd                   o_cmd
);
    import irc_pkg::*;

    localparam int CW = $clog2(MAX_TAPS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [CW-1:0]          r_left, n_left;
    logic [TAP_COUNT_W-1:0] r_tap_count;
    logic [CW-1:0]          w_taps;
    logic                   w_accept;

    // Counts above the store depth use the whole store.
    assign w_taps = (32'(r_tap_count) > MAX_TAPS) ? CW'(MAX_TAPS) : CW'(r_tap_count);
    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_command)
                        CMD_LOAD: begin
                            o_cmd.tap_we = 1'b1;
                        end
                        CMD_PROC: begin
                            o_cmd.hist_we = 1'b1;
                            o_cmd.start   = 1'b1;
                            n_left        = w_taps;
                            n_state       = (w_taps == '0) ? ST_DRAIN : ST_RUN;
                        end
                        CMD_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                o_cmd.issue = 1'b1;
                n_left      = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_stat.pipe_busy && i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_left      <= '0;
            r_tap_count <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            if (i_cfg_we) begin
                r_tap_count <= i_cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/irc_dp.sv -----
// Datapath for the convolver: tap store, history ring, multiply-accumulate
// pipeline, rounding/saturation and the output register. Depends on irc_pkg.
`default_nettype none

module irc_dp #(
    parameter int MAX_TAPS    = irc_pkg::DEF_MAX_TAPS,
    parameter int SAMPLE_BITS = irc_pkg::DEF_SAMPLE_BITS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  irc_pkg::t_dp_cmd                    i_cmd,
    output irc_pkg::t_dp_stat                   o_stat,
    input  wire  [irc_pkg::TAP_INDEX_W-1:0]     i_tap_index,
    input  wire  signed [SAMPLE_BITS-1:0]       i_value,
    irc_out_if.source                           o_out
);
    import irc_pkg::*;

    localparam int AW = $clog2(MAX_TAPS);
    localparam int FW = $clog2(MAX_TAPS + 1);
    localparam int PW = 2 * SAMPLE_BITS;
    localparam int FRAC_BITS = SAMPLE_BITS - 1;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) << FRAC_BITS) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    logic signed [SAMPLE_BITS-1:0] r_tap_mem  [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] r_hist_mem [MAX_TAPS];

    logic [AW-1:0]                 r_pos;
    logic [FW-1:0]                 r_fill;
    logic [AW-1:0]                 r_h;
    logic [AW-1:0]                 r_k;
    logic signed [SAMPLE_BITS-1:0] r_tap_q;
    logic signed [SAMPLE_BITS-1:0] r_hist_q;
    logic                          r_hist_ok;
    logic                          r_rd_vld;
    logic signed [PW-1:0]          r_prod;
    logic                          r_prod_vld;
    logic signed [ACC_W-1:0]       r_acc;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_clip;

    logic [AW-1:0]                 w_tap_addr;
    logic                          w_tap_in_range;
    logic signed [SAMPLE_BITS-1:0] w_hist_op;
    logic signed [ACC_W-1:0]       w_round;
    logic signed [ACC_W-1:0]       w_quot;
    logic signed [SAMPLE_BITS-1:0] w_sat;
    logic                          w_clip;

    assign w_tap_addr     = AW'(i_tap_index);
    assign w_tap_in_range = (32'(i_tap_index) < MAX_TAPS);

    // Tap store: undefined until loaded, so no clearing of any kind.
    always_ff @(posedge i_clk) begin
        if (i_cmd.tap_we && w_tap_in_range) begin
            r_tap_mem[w_tap_addr] <= i_value;
        end
        if (i_cmd.issue) begin
            r_tap_q <= r_tap_mem[r_k];
        end
    end

    // History ring. Entries at or above the fill count read as zero, which
    // stands in for clearing the whole ring on reset or a clear command.
    always_ff @(posedge i_clk) begin
        if (i_cmd.hist_we) begin
            r_hist_mem[r_pos] <= i_value;
        end
        if (i_cmd.issue) begin
            r_hist_q <= r_hist_mem[r_h];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_fill     <= '0;
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_rd_vld   <= i_cmd.issue;
            r_prod_vld <= r_rd_vld;
            if (i_cmd.clear) begin
                r_pos  <= '0;
                r_fill <= '0;
            end else if (i_cmd.hist_we) begin
                r_pos <= (r_pos == AW'(MAX_TAPS - 1)) ? '0 : r_pos + AW'(1);
                if (r_fill != FW'(MAX_TAPS)) begin
                    r_fill <= r_fill + FW'(1);
                end
            end
        end
    end

    // Address walk: taps count up from zero while the history steps back
    // from the newest sample.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_h <= r_pos;
            r_k <= '0;
        end else if (i_cmd.issue) begin
            r_h       <= (r_h == '0) ? AW'(MAX_TAPS - 1) : r_h - AW'(1);
            r_k       <= r_k + AW'(1);
        end
        if (i_cmd.issue) begin
            r_hist_ok <= (FW'(r_h) < r_fill);
        end
    end

    assign w_hist_op = r_hist_ok ? r_hist_q : '0;

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_prod <= r_tap_q * w_hist_op;
        end
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Round half up, drop the fraction, then saturate to the sample range.
    always_comb begin
        w_round = r_acc + ROUND_HALF;
        w_quot  = w_round >>> FRAC_BITS;
        if (w_quot > SAT_HI) begin
            w_sat  = SAT_HI[SAMPLE_BITS-1:0];
            w_clip = 1'b1;
        end else if (w_quot < SAT_LO) begin
            w_sat  = SAT_LO[SAMPLE_BITS-1:0];
            w_clip = 1'b1;
        end else begin
            w_sat  = w_quot[SAMPLE_BITS-1:0];
            w_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_sample <= w_sat;
            r_clip   <= w_clip;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_sample;
    assign o_out.clipped    = r_clip;

    assign o_stat.pipe_busy = r_rd_vld || r_prod_vld;
    assign o_stat.out_free  = !r_out_valid || o_out.ready;

endmodule

`default_nettype wire

// ----- rtl/impulse_response_convolver.sv -----
// Direct-form convolver: one multiply-accumulate per active tap per cycle.
// A process transfer holds the input off until its result is emitted, which
// waits for a free output register; load and clear leave the block idle.
// The last tap passes read, product and accumulator registers to the output.
// Reset clears control state and tap_count; the history reads as zero through
// a fill count, so no clearing pass runs. Taps are undefined until loaded.
`default_nettype none
`include "impulse_response_convolver_defines.svh"

module impulse_response_convolver #(
    parameter int MAX_TAPS    = irc_pkg::DEF_MAX_TAPS,
    parameter int SAMPLE_BITS = irc_pkg::DEF_SAMPLE_BITS
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [irc_pkg::TAP_COUNT_W-1:0]  i_cfg_wdata,
    irc_in_if.sink                           i_in,
    irc_out_if.source                        o_out
);
    import irc_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_ready;

    assign i_in.ready = w_ready;

    irc_ctrl #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_in.valid),
        .i_command   (i_in.command),
        .o_ready     (w_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    irc_dp #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_tap_index (i_in.tap_index),
        .i_value     (i_in.value),
        .o_out       (o_out)
    );

    `IRC_ASSERT_NOW(a_emit_needs_free_slot, w_cmd.emit, w_stat.out_free, "result emitted into a full output register")
    `IRC_ASSERT_NOW(a_no_accept_while_busy, w_ready, !(w_cmd.issue || w_cmd.emit), "input ready while a sum is in progress")
    `IRC_ASSERT_NEXT(a_emit_shows_result, w_cmd.emit, o_out.valid, "emitted result not presented")
    `IRC_ASSERT_NEXT(a_proc_blocks_input, i_in.valid && i_in.ready && (i_in.command == CMD_PROC), !i_in.ready, "input ready right after a process transfer")

endmodule

`default_nettype wire

// ----- test/tb_impulse_response_convolver.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for impulse_response_convolver: a directed table, then random phases
// of tap loads, samples and history clears, checked against typed values or an FIR predictor.
// Depends on irc_pkg, the irc_in_if/irc_out_if interfaces and the convolver RTL.

module tb_impulse_response_convolver;
    import irc_pkg::*;

    localparam int NTAPS         = DEF_MAX_TAPS;
    localparam int SBITS         = DEF_SAMPLE_BITS;
    localparam int FRAC          = SBITS - 1;
    localparam int RANDOM_ITEMS  = 555;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam longint SAT_HI = (longint'(1) <<< FRAC) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    typedef logic signed [SBITS-1:0] t_sample;

    typedef struct packed {
        t_sample sample;
        logic    clipped;
    } t_out_word;

    typedef enum bit {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CMD_W-1:0]       cmd;
        logic [TAP_INDEX_W-1:0] idx;
        t_sample                val;
        logic [TAP_COUNT_W-1:0] count;
        logic                   typed;
        t_sample                want_sample;
        logic                   want_clip;
    } t_dir_row;

    // Expected values are typed in only where they are obvious; the rest come from the predictor.
    localparam t_dir_row DIR_ROWS [24] = '{
        '{ROW_ITEM, CMD_PROC,  10'h000, 16'sh7FFF, 11'd0, 1'b1, 16'sh0000, 1'b0},
        '{ROW_ITEM, CMD_PROC,  10'h3FF, 16'sh8000, 11'd0, 1'b1, 16'sh0000, 1'b0},
        '{ROW_ITEM, CMD_SPARE, 10'h3FF, 16'shFFFF, 11'd0, 1'b0, 16'sh0000, 1'b0},
        '{ROW_ITEM, CMD_LOAD,  10'h000, 16'sh8000, 11'd0, 1'b0, 16'sh0000, 1'b0},
        '{ROW_ITEM, CMD_LOAD,  10'h3FF, 16'sh7FFF, 11'd0, 1'b0, 16'sh0000, 1'b0},
        '{ROW_ITEM, CMD_LOAD,  10'h001, 16'sh7FFF, 11'd0, 1'b0, 16'sh0000, 1'b0},
        '{ROW_ITEM, CMD_LOAD,  10'h002, 16'sh0000, 11'd0, 1'b0, 16'sh0000, 1'b0},
        '{ROW_ITEM, CMD_LOAD,  10'h003, 16'shFFFF, 11'd0, 1'b0, 16'sh0000, 1'b0},
        '{ROW_CFG,  CMD_LOAD,  10'h000, 16'sh0000, 11'd1, 1'b0, 16'sh0000, 1'b0},
        '{ROW_ITEM, CMD_CLEAR, 10'h000, 16'sh0000, 11'd0, 1'b0, 16'sh0000, 1'b0},
        '{ROW_ITEM, CMD_PROC,  10'h000, 16'sh8000, 11'd0, 1'b1, 16'sh7FFF, 1'b1},
        '{ROW_ITEM, CMD_PROC,  10'h000, 16'sh0000, 11'd0, 1'b1, 16'sh0000, 1'b0},
        '{ROW_CFG,  CMD_LOAD,  10'h000, 16'sh0000, 11'd2, 1'b0, 16'sh0000, 1'b0},
        '{ROW_ITEM, CMD_CLEAR, 10'h000, 16'sh0000, 11'd0, 1'b0, 16'sh0000, 1'b0},
        '{ROW_ITEM, CMD_PROC,  10'h000, 16'sh8000, 11'd0, 1'b1, 16'sh7FFF, 1'b1},
        '{ROW_ITEM, CMD_PROC,  10'h000, 16'sh7FFF, 11'd0, 1'b1, 16'sh8000, 1'b1},
        '{ROW_ITEM, CMD_PROC,  10'h000, 16'sh7FFF, 11'd0, 1'b0, 16'sh0000, 1'b0},
        '{ROW_CFG,  CMD_LOAD,  10'h000, 16'sh0000, 11'd4, 1'b0, 16'sh0000, 1'b0},
        '{ROW_ITEM, CMD_PROC,  10'h000, 16'sh0001, 11'd0, 1'b0, 16'sh0000, 1'b0},
        '{ROW_ITEM, CMD_PROC,  10'h000, 16'shFFFF, 11'd0, 1'b0, 16'sh0000, 1'b0},
        '{ROW_ITEM, CMD_LOAD,  10'h155, 16'shAAAA, 11'd0, 1'b0, 16'sh0000, 1'b0},
        '{ROW_ITEM, CMD_PROC,  10'h2AA, 16'sh5555, 11'd0, 1'b0, 16'sh0000, 1'b0},
        '{ROW_CFG,  CMD_LOAD,  10'h000, 16'sh0000, 11'd0, 1'b0, 16'sh0000, 1'b0},
        '{ROW_ITEM, CMD_PROC,  10'h000, 16'sh4000, 11'd0, 1'b1, 16'sh0000, 1'b0}
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [TAP_COUNT_W-1:0] cfg_wdata;

    irc_in_if  #(.SAMPLE_BITS(SBITS)) in_ch ();
    irc_out_if #(.SAMPLE_BITS(SBITS)) out_ch ();

    impulse_response_convolver #(
        .MAX_TAPS    (NTAPS),
        .SAMPLE_BITS (SBITS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always #1 clk = ~clk;

    // Predictor state: taps, sample history, write slot and the tap count in force.
    t_sample                coef     [NTAPS];
    bit                     coef_set [NTAPS];
    t_sample                past     [NTAPS];
    logic [TAP_INDEX_W-1:0] wr_slot;
    logic [TAP_COUNT_W-1:0] active_taps;

    t_out_word   due_out [$];
    int unsigned mismatches = 0;
    bit          calm = 1'b0;
    bit          hold_request = 1'b0;

    // Applies one command to the predictor state; returns 1 when it yields an output sample.
    function automatic bit convolve_step(input logic [CMD_W-1:0] cmd,
                                         input logic [TAP_INDEX_W-1:0] idx,
                                         input t_sample val,
                                         output t_out_word res);
        longint                 acc;
        longint                 q;
        int                     n;
        logic [TAP_INDEX_W-1:0] h;
        res = '0;
        case (cmd)
            CMD_LOAD: begin
                coef[idx] = val;
                coef_set[idx] = 1'b1;
                return 1'b0;
            end
            CMD_CLEAR: begin
                foreach (past[k]) past[k] = '0;
                wr_slot = '0;
                return 1'b0;
            end
            CMD_PROC: ;
            default: return 1'b0;
        endcase
        past[wr_slot] = val;
        n = (active_taps > NTAPS) ? NTAPS : int'(active_taps);
        acc = 0;
        h = wr_slot;
        for (int k = 0; k < n; k++) begin
            acc += longint'(coef[k]) * longint'(past[h]);
            h = h - 1'b1;
        end
        wr_slot = wr_slot + 1'b1;
        q = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        if (q > SAT_HI) begin
            res.sample = t_sample'(SAT_HI);
            res.clipped = 1'b1;
        end else if (q < SAT_LO) begin
            res.sample = t_sample'(SAT_LO);
            res.clipped = 1'b1;
        end else begin
            res.sample = t_sample'(q);
        end
        return 1'b1;
    endfunction

    function automatic t_sample pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return t_sample'($urandom_range(0, 65535));
        endcase
    endfunction

    // Offers one item, waits for its transfer and records what the block should answer.
    task automatic offer_item(input logic [CMD_W-1:0] cmd, input logic [TAP_INDEX_W-1:0] idx,
                              input t_sample val, input bit typed, input t_out_word typed_out);
        bit        took;
        t_out_word res;
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.command   <= cmd;
        in_ch.tap_index <= idx;
        in_ch.value     <= val;
        do begin
            @(negedge clk);
            took = in_ch.ready;
            @(posedge clk);
        end while (!took);
        if (convolve_step(cmd, idx, val, res))
            due_out = {due_out, (typed ? typed_out : res)};
    endtask

    // The tap count is only written once the block has drained.
    task automatic settle_and_set(input logic [TAP_COUNT_W-1:0] count);
        in_ch.valid <= 1'b0;
        while (due_out.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wdata <= count;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        active_taps = count;
    endtask

    // Every tap that the count brings into use must be loaded before any sample reads it.
    task automatic fill_taps(input logic [TAP_COUNT_W-1:0] count, output int unsigned loads);
        int m;
        loads = 0;
        m = (count > NTAPS) ? NTAPS : int'(count);
        for (int k = 0; k < m; k++)
            if (!coef_set[k]) begin
                offer_item(CMD_LOAD, TAP_INDEX_W'(k), pick_sample(), 1'b0, '0);
                loads++;
            end
    endtask

    initial begin : stimulus
        int unsigned            issued;
        int unsigned            phase;
        int unsigned            burst;
        int unsigned            roll;
        int unsigned            loads;
        logic [TAP_COUNT_W-1:0] count;
        logic [CMD_W-1:0]       cmd;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.command   <= CMD_LOAD;
        in_ch.tap_index <= '0;
        in_ch.value     <= '0;
        foreach (past[k]) begin
            past[k] = '0;
            coef[k] = '0;
            coef_set[k] = 1'b0;
        end
        wr_slot = '0;
        active_taps = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_ROWS[r]) begin
            if (DIR_ROWS[r].kind == ROW_CFG)
                settle_and_set(DIR_ROWS[r].count);
            else
                offer_item(DIR_ROWS[r].cmd, DIR_ROWS[r].idx, DIR_ROWS[r].val, DIR_ROWS[r].typed,
                           t_out_word'{DIR_ROWS[r].want_sample, DIR_ROWS[r].want_clip});
        end

        issued = 0;
        phase = 0;
        while (issued < RANDOM_ITEMS) begin
            case (phase)
                1: count = 11'd3;
                3: count = '0;
                default: begin
                    roll = $urandom_range(0, 9);
                    if (roll < 6)
                        count = TAP_COUNT_W'($urandom_range(1, 8));
                    else if (roll < 8)
                        count = TAP_COUNT_W'($urandom_range(9, 40));
                    else if (roll < 9)
                        count = '0;
                    else
                        count = TAP_COUNT_W'($urandom_range(41, 128));
                end
            endcase
            if (issued + 80 >= RANDOM_ITEMS)
                calm = 1'b1;
            settle_and_set(count);
            fill_taps(count, loads);
            issued += loads;
            // With only three taps the block turns samples around fast, so a long output
            // stall here backs up into the input.
            if (phase == 1)
                hold_request = 1'b1;
            if (phase == 1)
                burst = 60;
            else
                burst = $urandom_range(20, 60);
            repeat (burst) begin
                roll = $urandom_range(0, 99);
                if (roll < 72)
                    cmd = CMD_PROC;
                else if (roll < 88)
                    cmd = CMD_LOAD;
                else if (roll < 93)
                    cmd = CMD_CLEAR;
                else
                    cmd = CMD_SPARE;
                offer_item(cmd, TAP_INDEX_W'($urandom_range(0, NTAPS - 1)), pick_sample(),
                           1'b0, '0);
                if (cmd != CMD_SPARE)
                    issued++;
            end
            phase++;
        end

        in_ch.valid <= 1'b0;
        while (due_out.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb_impulse_response_convolver: clean");
        else
            $display("tb_impulse_response_convolver: errors");
        $finish;
    end

    initial begin : result_side
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Sampled mid-cycle, so the transfer seen here completes at the next rising edge.
    always @(negedge clk) begin : check_out
        t_out_word want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (due_out.size() == 0) begin
                $display("%0t: output transfer with none due: expected none, actual %0d/%0b",
                         $time, out_ch.sample_out, out_ch.clipped);
                mismatches++;
            end else begin
                want = due_out.pop_front();
                if (out_ch.sample_out !== want.sample) begin
                    $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                             $time, want.sample, out_ch.sample_out);
                    mismatches++;
                end
                if (out_ch.clipped !== want.clipped) begin
                    $display("%0t: clipped mismatch: expected %0b, actual %0b",
                             $time, want.clipped, out_ch.clipped);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        #1_000_000;
        $display("tb_impulse_response_convolver: errors");
        $finish;
    end

endmodule
